>>> hdl/hreg_pkg.sv
// Shared types, constants and helpers for the HDR region exposure grading block.
// Holds the pixel word structs, register indexes, reset values and fixed-point tables.
// No dependencies.
package hreg_pkg;

  localparam int PIX_W      = 28;
  localparam int CH_W       = 27;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int BAND_W     = 48;
  localparam int SOFT_W     = 16;
  localparam int MAX_BANDS  = 3;
  localparam int NUM_BANDS_DEF = 3;

  typedef struct packed {
    logic signed [PIX_W-1:0] red_nits;
    logic signed [PIX_W-1:0] green_nits;
    logic signed [PIX_W-1:0] blue_nits;
  } pix_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] red_graded;
    logic signed [PIX_W-1:0] green_graded;
    logic signed [PIX_W-1:0] blue_graded;
  } pix_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND0    = 3'd0,
    CFG_BAND1    = 3'd1,
    CFG_BAND2    = 3'd2,
    CFG_SOFTNESS = 3'd3,
    CFG_CEILING  = 3'd4
  } cfg_idx_t;

  localparam logic [BAND_W-1:0] BAND0_RST   = 48'd183961765;
  localparam logic [BAND_W-1:0] BAND1_RST   = 48'd217516791;
  localparam logic [BAND_W-1:0] BAND2_RST   = 48'd60226478;
  localparam logic [SOFT_W-1:0] SOFT_RST    = 16'd4096;
  localparam logic [CH_W-1:0]   CEILING_RST = 27'd40960000;
  localparam logic [SOFT_W-1:0] SOFT_MIN    = 16'd4;

  // Rec.2020 luma weights in Q16.
  localparam logic [15:0] LUMA_R = 16'd17216;
  localparam logic [15:0] LUMA_G = 16'd44433;
  localparam logic [15:0] LUMA_B = 16'd3886;

  localparam logic [31:0] Q30_ONE  = 32'd1073741824;
  localparam logic [29:0] EXP_LIN  = 30'd744261118;
  localparam logic [30:0] ROOT_TABLE [8] = '{
    31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
    31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033
  };

  localparam int LOG_ITERS  = 8;
  localparam int DIV_BITS   = 16;
  localparam int DIV_PER_ST = 2;
  localparam int DIV_STAGES = DIV_BITS / DIV_PER_ST;
  localparam int GAIN_STEPS = 8;

  // A negative channel counts as zero.
  function automatic logic [CH_W-1:0] chan_clamp(input logic signed [PIX_W-1:0] v);
    return v[PIX_W-1] ? '0 : v[CH_W-1:0];
  endfunction

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [SOFT_W:0] div_step(input logic [SOFT_W-1:0] r,
                                               input logic [SOFT_W-1:0] d);
    logic [SOFT_W:0] r2;
    logic [SOFT_W:0] diff;
    r2   = {r, 1'b0};
    diff = r2 - {1'b0, d};
    if (r2 >= {1'b0, d}) begin
      return {1'b1, diff[SOFT_W-1:0]};
    end
    return {1'b0, r2[SOFT_W-1:0]};
  endfunction

endpackage

>>> hdl/hdr_region_exposure_grade.sv
// HDR region exposure grading: luma, log2, band masks, exp2 gain and saturation.
// Accepts one pixel word per clock whenever the output is not stalled.
// A stalled output holds every stage in place; no word is dropped or repeated.
// Synchronous active-high reset empties the pipeline and restores the register defaults.
// The log2 squarings and the exp2 products take one stage per step, the divider two bits.
// Depends on hreg_pkg.
module hdr_region_exposure_grade #(
  parameter int NUM_BANDS = hreg_pkg::NUM_BANDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  hreg_pkg::pix_in_t                    pixel,
  output logic                                 graded_valid,
  input  logic                                 graded_ready,
  output hreg_pkg::pix_out_t                   graded,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hreg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hreg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hreg_pkg::*;

  localparam int NS = 39;

  // Configuration registers.
  logic [BAND_W-1:0] band_cfg [MAX_BANDS];
  logic [SOFT_W-1:0] softness;
  logic [CH_W-1:0]   ceiling;
  logic [SOFT_W-1:0] soft_eff;
  logic              grade_on;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      band_cfg[0] <= BAND0_RST;
      band_cfg[1] <= BAND1_RST;
      band_cfg[2] <= BAND2_RST;
      softness    <= SOFT_RST;
      ceiling     <= CEILING_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BAND0:    band_cfg[0] <= cfg_data;
        CFG_BAND1:    band_cfg[1] <= cfg_data;
        CFG_BAND2:    band_cfg[2] <= cfg_data;
        CFG_SOFTNESS: softness    <= cfg_data[SOFT_W-1:0];
        CFG_CEILING:  ceiling     <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign soft_eff = (softness < SOFT_MIN) ? SOFT_MIN : softness;

  always_comb begin
    grade_on = 1'b0;
    for (int b = 0; b < NUM_BANDS; b++) begin
      if (band_cfg[b][47:32] != '0) grade_on = 1'b1;
    end
  end

  // Pipeline control: every stage advances unless the output word is stuck.
  logic [NS-1:0] vld;
  logic          adv;
  pix_in_t       raw_q [NS];

  assign adv          = !vld[NS-1] || graded_ready;
  assign pixel_ready  = adv;
  assign graded_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], pixel_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      raw_q[0] <= pixel;
      for (int s = 1; s < NS; s++) raw_q[s] <= raw_q[s-1];
    end
  end

  // Luma products and sum.
  logic [42:0] lp_r, lp_g, lp_b;
  logic [42:0] luma_sum;
  logic [CH_W-1:0] y2;

  always_ff @(posedge clk) begin
    if (adv) begin
      lp_r <= 43'(chan_clamp(raw_q[0].red_nits))   * 43'(LUMA_R);
      lp_g <= 43'(chan_clamp(raw_q[0].green_nits)) * 43'(LUMA_G);
      lp_b <= 43'(chan_clamp(raw_q[0].blue_nits))  * 43'(LUMA_B);
    end
  end

  assign luma_sum = lp_r + lp_g + lp_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      y2 <= (luma_sum[42:16] == '0) ? 27'd1 : luma_sum[42:16];
    end
  end

  // Normalize the luma to [2^30, 2^31) and note the exponent.
  logic [4:0]  msb;
  logic [56:0] norm;
  logic [30:0] sq_m [LOG_ITERS+1];
  logic [7:0]  sq_f [LOG_ITERS+1];
  logic [4:0]  sq_p [LOG_ITERS+1];

  always_comb begin
    msb = '0;
    for (int i = 0; i < CH_W; i++) begin
      if (y2[i]) msb = 5'(i);
    end
  end

  assign norm = (57'(y2) << 30) >> msb;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_m[0] <= norm[30:0];
      sq_f[0] <= '0;
      sq_p[0] <= msb;
    end
  end

  // Each squaring yields one fraction bit of the log2.
  for (genvar i = 0; i < LOG_ITERS; i++) begin : g_log
    logic [61:0] sq_prod;
    assign sq_prod = 62'(sq_m[i]) * 62'(sq_m[i]);
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_m[i+1] <= sq_prod[61] ? sq_prod[61:31] : sq_prod[60:30];
        sq_f[i+1] <= {sq_f[i][6:0], sq_prod[61]};
        sq_p[i+1] <= sq_p[i];
      end
    end
  end

  logic signed [12:0] ly;

  always_ff @(posedge clk) begin
    if (adv) begin
      ly <= 13'({sq_p[LOG_ITERS], sq_f[LOG_ITERS]}) - 13'd3072;
    end
  end

  // Per-band mask and its EV-weighted product.
  logic [33:0] band_prod [NUM_BANDS];

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
    logic signed [21:0] y12, lo12, hi12, soft22, nr, nf, nmin;
    logic [SOFT_W-1:0]  dv_rem  [DIV_STAGES+1];
    logic [DIV_BITS-1:0] dv_q   [DIV_STAGES+1];
    logic               dv_zero [DIV_STAGES+1];
    logic               dv_full [DIV_STAGES+1];
    logic [16:0]        m22, m23, m2, mask;
    logic [33:0]        mm;
    logic [17:0]        wt;
    logic [34:0]        mw;
    logic [15:0]        ev;

    assign y12    = {{5{ly[12]}}, ly, 4'b0};
    assign lo12   = {{2{band_cfg[b][15]}}, band_cfg[b][15:0], 4'b0};
    assign hi12   = {{2{band_cfg[b][31]}}, band_cfg[b][31:16], 4'b0};
    assign soft22 = {6'b0, soft_eff};
    assign nr     = y12 - lo12 + soft22;
    assign nf     = hi12 + soft22 - y12;
    // The mask is the smaller ramp, and both ramps share a divisor.
    assign nmin   = (nr < nf) ? nr : nf;

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_zero[0] <= (nmin <= 22'sd0);
        dv_full[0] <= (nmin >= soft22);
        dv_rem[0]  <= nmin[SOFT_W-1:0];
        dv_q[0]    <= '0;
      end
    end

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [SOFT_W:0] st1, st2;
      assign st1 = div_step(dv_rem[j], soft_eff);
      assign st2 = div_step(st1[SOFT_W-1:0], soft_eff);
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[j+1]  <= st2[SOFT_W-1:0];
          dv_q[j+1]    <= {dv_q[j][DIV_BITS-3:0], st1[SOFT_W], st2[SOFT_W]};
          dv_zero[j+1] <= dv_zero[j];
          dv_full[j+1] <= dv_full[j];
        end
      end
    end

    assign mm = 34'(m22) * 34'(m22);
    assign wt = 18'd196608 - {m23, 1'b0};
    assign mw = 35'(m2) * 35'(wt);
    assign ev = band_cfg[b][47:32];

    always_ff @(posedge clk) begin
      if (adv) begin
        if (dv_full[DIV_STAGES]) begin
          m22 <= 17'h10000;
        end else if (dv_zero[DIV_STAGES]) begin
          m22 <= '0;
        end else begin
          m22 <= {1'b0, dv_q[DIV_STAGES]};
        end
        m2           <= mm[32:16];
        m23          <= m22;
        mask         <= mw[32:16];
        band_prod[b] <= {{18{ev[15]}}, ev} * {17'b0, mask};
      end
    end
  end

  // Exposure change in stops, biased by 32 stops to keep the floor positive.
  logic [35:0] total;
  logic [6:0]  ip_biased;
  logic [5:0]  sh26;
  logic [15:0] f26;

  always_comb begin
    total = 36'h2_0000_0000;
    for (int b = 0; b < NUM_BANDS; b++) begin
      total = total + {{2{band_prod[b][33]}}, band_prod[b]};
    end
  end

  assign ip_biased = total[34:28];

  always_ff @(posedge clk) begin
    if (adv) begin
      sh26 <= 6'(7'd62 - ip_biased);
      f26  <= total[27:12];
    end
  end

  // exp2 of the fraction: one root multiply per stage, then the linear tail.
  logic [31:0] gn    [GAIN_STEPS+1];
  logic [15:0] gn_f  [GAIN_STEPS+1];
  logic [5:0]  gn_sh [GAIN_STEPS+1];
  logic [37:0] lin_prod;
  logic [30:0] fac;

  assign gn[0]    = Q30_ONE;
  assign gn_f[0]  = f26;
  assign gn_sh[0] = sh26;

  for (genvar k = 0; k < GAIN_STEPS; k++) begin : g_gain
    logic [63:0] gp;
    assign gp = 64'(gn[k]) * 64'(ROOT_TABLE[k]);
    always_ff @(posedge clk) begin
      if (adv) begin
        gn[k+1]    <= gn_f[k][15-k] ? gp[61:30] : gn[k];
        gn_f[k+1]  <= gn_f[k];
        gn_sh[k+1] <= gn_sh[k];
      end
    end
  end

  assign lin_prod = 38'(gn_f[GAIN_STEPS-1][7:0]) * 38'(EXP_LIN);

  always_ff @(posedge clk) begin
    if (adv) begin
      fac <= 31'(Q30_ONE) + 31'(lin_prod[37:16]);
    end
  end

  logic [63:0] gf;
  logic [31:0] gain35;
  logic [5:0]  sh35, sh36;

  assign gf = 64'(gn[GAIN_STEPS]) * 64'(fac);

  always_ff @(posedge clk) begin
    if (adv) begin
      gain35 <= gf[61:30];
      sh35   <= gn_sh[GAIN_STEPS];
      sh36   <= sh35;
    end
  end

  // Channel scaling, shift and saturation.
  logic signed [PIX_W-1:0] raw35 [3];
  logic signed [PIX_W-1:0] raw37 [3];
  logic [PIX_W-1:0]        out_w [3];

  assign raw35[0] = raw_q[35].red_nits;
  assign raw35[1] = raw_q[35].green_nits;
  assign raw35[2] = raw_q[35].blue_nits;
  assign raw37[0] = raw_q[37].red_nits;
  assign raw37[1] = raw_q[37].green_nits;
  assign raw37[2] = raw_q[37].blue_nits;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [58:0]     cp, sv;
    logic            sat37;
    logic [CH_W-1:0] v37;

    assign sv = cp >> sh36;

    always_ff @(posedge clk) begin
      if (adv) begin
        cp    <= 59'(chan_clamp(raw35[c])) * 59'(gain35);
        sat37 <= |sv[58:CH_W];
        v37   <= sv[CH_W-1:0];
        if (!grade_on) begin
          out_w[c] <= raw37[c];
        end else if (sat37 || (v37 > ceiling)) begin
          out_w[c] <= {1'b0, ceiling};
        end else begin
          out_w[c] <= {1'b0, v37};
        end
      end
    end
  end

  assign graded.red_graded   = out_w[0];
  assign graded.green_graded = out_w[1];
  assign graded.blue_graded  = out_w[2];

endmodule
